@@ hw/rtl/accel_tilt_angles_macros.svh @@
// assertion macros for the tilt angle block
`ifndef ACCEL_TILT_ANGLES_MACROS_SVH
`define ACCEL_TILT_ANGLES_MACROS_SVH

// checked at every edge, reset included
`define ATA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// checked outside reset only
`define ATA_ASSERT(label, prop, msg) \
  `ATA_ASSERT_RST(label, disable iff (!rst_n) prop, msg)

`endif

@@ hw/rtl/ata_pkg.sv @@
`default_nettype none
package ata_pkg;

  localparam int SAMPLE_BITS_DEF = 8;
  localparam int FRAC_BITS       = 16;

  // normalised operands have their top bit at position NORM_W-1
  localparam int NORM_W      = 41;
  localparam int NORM_STAGES = 3;
  localparam int NORM_SH_A [NORM_STAGES] = '{32, 8, 2};
  localparam int NORM_SH_B [NORM_STAGES] = '{16, 4, 1};

  localparam int CORDIC_STEPS = 22;
  localparam int CW           = 44;
  localparam int ZW           = 24;
  localparam int CORDIC_LAT   = NORM_STAGES + CORDIC_STEPS + 1;

  localparam int ANG_W       = 15;
  localparam int MASK_W      = 3;
  localparam int RIGHT_ANGLE = 9000;

  localparam int ROLL_IDX  = 0;
  localparam int PITCH_IDX = 1;
  localparam int TILT_IDX  = 2;

  // atan(2^-i) in 1/25600 degree
  localparam int ATAN_T [CORDIC_STEPS] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1
  };

  typedef struct packed {
    logic neg;
    logic zero;
    logic right;
    logic undef;
  } ang_side_t;

endpackage
`default_nettype wire

@@ hw/rtl/ata_if.sv @@
`default_nettype none
interface ata_in_if import ata_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

interface ata_out_if import ata_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] roll_angle;
  logic signed [ANG_W-1:0] pitch_angle;
  logic signed [ANG_W-1:0] vertical_tilt;
  logic [MASK_W-1:0]       undefined_mask;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output vertical_tilt, output undefined_mask, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle,
                input vertical_tilt, input undefined_mask, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ata_isqrt.sv @@
`default_nettype none
module ata_isqrt import ata_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic [2*SAMPLE_BITS-1:0]              sq,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]           root
);
  localparam int RW  = SAMPLE_BITS + FRAC_BITS;
  localparam int RM  = RW + 3;
  localparam int SQW = 2 * SAMPLE_BITS;

  // one root bit per stage, radicand is sq with 2*FRAC_BITS zero bits below
  logic [SQW-1:0] sq_r   [RW];
  logic [RM-1:0]  rem_r  [RW];
  logic [RW-1:0]  root_r [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [SQW-1:0] sq_p;
    logic [RM-1:0]  rem_p;
    logic [RW-1:0]  root_p;
    logic [1:0]     pair;
    logic [RM-1:0]  rem2;
    logic [RM-1:0]  trial;
    logic [RM-1:0]  rem_nxt;
    logic [RW-1:0]  root_nxt;

    if (i == 0) begin : g_first
      assign sq_p   = sq;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign sq_p   = sq_r[i-1];
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
    end

    if (i < SAMPLE_BITS) begin : g_bits
      assign pair = sq_p[SQW-1-2*i -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      rem2  = {rem_p[RM-3:0], pair};
      trial = RM'({root_p, 2'b01});
      if (rem2 >= trial) begin
        rem_nxt  = rem2 - trial;
        root_nxt = {root_p[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem2;
        root_nxt = {root_p[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[i]   <= sq_p;
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
      end
    end
  end

  assign root = root_r[RW-1];
endmodule
`default_nettype wire

@@ hw/rtl/ata_cordic.sv @@
`default_nettype none
module ata_cordic import ata_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [SAMPLE_BITS+FRAC_BITS-1:0]    num_mag,
  input  wire logic [SAMPLE_BITS+FRAC_BITS-1:0]    den_mag,
  input  wire ang_side_t                           side_in,
  output logic signed [ANG_W-1:0]                  angle,
  output logic                                     undef
);
  localparam int HW = ZW - 8;

  // normalisation, two conditional shifts per stage
  logic [NORM_W-1:0] nx_r    [NORM_STAGES];
  logic [NORM_W-1:0] ny_r    [NORM_STAGES];
  ang_side_t         nside_r [NORM_STAGES];

  for (genvar s = 0; s < NORM_STAGES; s++) begin : g_norm
    logic [NORM_W-1:0] px, py, qx, qy;
    ang_side_t         pside;

    if (s == 0) begin : g_first
      assign px    = NORM_W'(den_mag);
      assign py    = NORM_W'(num_mag);
      assign pside = side_in;
    end else begin : g_next
      assign px    = nx_r[s-1];
      assign py    = ny_r[s-1];
      assign pside = nside_r[s-1];
    end

    always_comb begin
      qx = px;
      qy = py;
      if (((qx | qy) >> (NORM_W - NORM_SH_A[s])) == '0) begin
        qx = qx << NORM_SH_A[s];
        qy = qy << NORM_SH_A[s];
      end
      if (((qx | qy) >> (NORM_W - NORM_SH_B[s])) == '0) begin
        qx = qx << NORM_SH_B[s];
        qy = qy << NORM_SH_B[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx_r[s]    <= qx;
        ny_r[s]    <= qy;
        nside_r[s] <= pside;
      end
    end
  end

  // vectoring rotations, one per stage
  logic signed [CW-1:0] cx_r    [CORDIC_STEPS];
  logic signed [CW-1:0] cy_r    [CORDIC_STEPS];
  logic signed [ZW-1:0] cz_r    [CORDIC_STEPS];
  ang_side_t            cside_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] px, py, dx, dy, qx, qy;
    logic signed [ZW-1:0] pz, qz;
    ang_side_t            pside;

    if (i == 0) begin : g_first
      assign px    = CW'(nx_r[NORM_STAGES-1]);
      assign py    = CW'(ny_r[NORM_STAGES-1]);
      assign pz    = '0;
      assign pside = nside_r[NORM_STAGES-1];
    end else begin : g_next
      assign px    = cx_r[i-1];
      assign py    = cy_r[i-1];
      assign pz    = cz_r[i-1];
      assign pside = cside_r[i-1];
    end

    always_comb begin
      dx = py >>> i;
      dy = px >>> i;
      if (!py[CW-1]) begin
        qx = px + dx;
        qy = py - dy;
        qz = pz + ZW'(ATAN_T[i]);
      end else begin
        qx = px - dx;
        qy = py + dy;
        qz = pz - ZW'(ATAN_T[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i]    <= qx;
        cy_r[i]    <= qy;
        cz_r[i]    <= qz;
        cside_r[i] <= pside;
      end
    end
  end

  // rounding to hundredths, clamp and special cases
  logic signed [ZW-1:0]    zl;
  logic signed [ZW-1:0]    zr;
  logic [HW-1:0]           hmag;
  logic signed [ANG_W-1:0] mag_s;
  logic signed [ANG_W-1:0] angle_nxt;
  ang_side_t               fside;
  logic signed [ANG_W-1:0] angle_r;
  logic                    undef_r;

  always_comb begin
    zl    = cz_r[CORDIC_STEPS-1];
    fside = cside_r[CORDIC_STEPS-1];
    zr    = zl + ZW'(128);
    if (zl[ZW-1]) begin
      hmag = '0;
    end else begin
      hmag = zr[ZW-1:8];
    end
    if (hmag > HW'(RIGHT_ANGLE)) begin
      hmag = HW'(RIGHT_ANGLE);
    end
    if (fside.zero) begin
      mag_s = '0;
    end else if (fside.right) begin
      mag_s = ANG_W'(RIGHT_ANGLE);
    end else begin
      mag_s = ANG_W'(hmag);
    end
    angle_nxt = fside.neg ? -mag_s : mag_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
      undef_r <= fside.undef;
    end
  end

  assign angle = angle_r;
  assign undef = undef_r;
endmodule
`default_nettype wire

@@ hw/rtl/accel_tilt_angles.sv @@
// accel_tilt_angles: roll, pitch and tilt from vertical of one signed
// three-axis sample, in hundredths of a degree rounded to nearest. a new
// item is taken every cycle while the pipeline is not held. a sample passes
// through the entry stage, the square-root pipeline (one root bit per
// stage), the operand normalisation (3 stages), 22 arctangent rotation
// stages and a rounding stage, then the output register. a zero denominator
// gives +-9000 by the numerator's sign, zero over zero gives 0 and sets the
// angle's mask bit. the whole pipeline holds while its last stage is full
// and the output register is full and not taken; it moves as one, so
// bubbles inside it are carried along rather than squeezed out.
`default_nettype none
module accel_tilt_angles import ata_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ata_in_if.sink    in_chan,
  ata_out_if.source out_chan
);
  localparam int RW  = SAMPLE_BITS + FRAC_BITS;
  localparam int SQW = 2 * SAMPLE_BITS;
  localparam int TOT = 1 + RW + CORDIC_LAT;

  logic           pipe_en;
  logic [TOT-1:0] v_r;
  logic           out_valid_r;

  // whole pipeline moves together
  assign pipe_en       = !v_r[TOT-1] || !out_valid_r || out_chan.ready;
  assign in_chan.ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (pipe_en) begin
      v_r <= {v_r[TOT-2:0], in_chan.valid};
    end
  end

  // entry stage: magnitudes, squares and the special-case flags
  logic [SAMPLE_BITS-1:0] ax, ay, az;
  logic [SQW-1:0]         sxx, syy, szz;
  logic                   xz_n, yz_n, zz_n;
  ang_side_t [2:0]        side_nxt;

  always_comb begin
    ax   = in_chan.accel_x[SAMPLE_BITS-1] ? (~in_chan.accel_x + 1'b1) : in_chan.accel_x;
    ay   = in_chan.accel_y[SAMPLE_BITS-1] ? (~in_chan.accel_y + 1'b1) : in_chan.accel_y;
    az   = in_chan.accel_z[SAMPLE_BITS-1] ? (~in_chan.accel_z + 1'b1) : in_chan.accel_z;
    sxx  = ax * ax;
    syy  = ay * ay;
    szz  = az * az;
    xz_n = (in_chan.accel_x == '0);
    yz_n = (in_chan.accel_y == '0);
    zz_n = (in_chan.accel_z == '0);

    // roll: x over the yz magnitude
    side_nxt[ROLL_IDX].neg   = in_chan.accel_x[SAMPLE_BITS-1];
    side_nxt[ROLL_IDX].zero  = xz_n;
    side_nxt[ROLL_IDX].right = !xz_n && yz_n && zz_n;
    side_nxt[ROLL_IDX].undef = xz_n && yz_n && zz_n;
    // pitch: y over the xz magnitude
    side_nxt[PITCH_IDX].neg   = in_chan.accel_y[SAMPLE_BITS-1];
    side_nxt[PITCH_IDX].zero  = yz_n;
    side_nxt[PITCH_IDX].right = !yz_n && xz_n && zz_n;
    side_nxt[PITCH_IDX].undef = yz_n && xz_n && zz_n;
    // tilt: xy magnitude over z, numerator never negative
    side_nxt[TILT_IDX].neg   = in_chan.accel_z[SAMPLE_BITS-1];
    side_nxt[TILT_IDX].zero  = xz_n && yz_n;
    side_nxt[TILT_IDX].right = !(xz_n && yz_n) && zz_n;
    side_nxt[TILT_IDX].undef = xz_n && yz_n && zz_n;
  end

  logic [SQW-1:0]         s_yz_r, s_xz_r, s_xy_r;
  logic [SAMPLE_BITS-1:0] ax_r, ay_r, az_r;
  ang_side_t [2:0]        side_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s_yz_r <= syy + szz;
      s_xz_r <= sxx + szz;
      s_xy_r <= sxx + syy;
      ax_r   <= ax;
      ay_r   <= ay;
      az_r   <= az;
      side_r <= side_nxt;
    end
  end

  // three root pipelines in parallel
  logic [RW-1:0] mag_yz, mag_xz, mag_xy;

  ata_isqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_sqrt_yz (
    .clk(clk), .en(pipe_en), .sq(s_yz_r), .root(mag_yz)
  );
  ata_isqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_sqrt_xz (
    .clk(clk), .en(pipe_en), .sq(s_xz_r), .root(mag_xz)
  );
  ata_isqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_sqrt_xy (
    .clk(clk), .en(pipe_en), .sq(s_xy_r), .root(mag_xy)
  );

  // sample magnitudes and flags ride alongside the roots
  logic [SAMPLE_BITS-1:0] ax_d_r   [RW];
  logic [SAMPLE_BITS-1:0] ay_d_r   [RW];
  logic [SAMPLE_BITS-1:0] az_d_r   [RW];
  ang_side_t [2:0]        side_d_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_dly
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          ax_d_r[k]   <= ax_r;
          ay_d_r[k]   <= ay_r;
          az_d_r[k]   <= az_r;
          side_d_r[k] <= side_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          ax_d_r[k]   <= ax_d_r[k-1];
          ay_d_r[k]   <= ay_d_r[k-1];
          az_d_r[k]   <= az_d_r[k-1];
          side_d_r[k] <= side_d_r[k-1];
        end
      end
    end
  end

  // arctangent per angle
  logic signed [ANG_W-1:0] roll_a, pitch_a, tilt_a;
  logic [MASK_W-1:0]       mask_a;

  ata_cordic #(.SAMPLE_BITS(SAMPLE_BITS)) u_cordic_roll (
    .clk(clk), .en(pipe_en),
    .num_mag({ax_d_r[RW-1], FRAC_BITS'(0)}), .den_mag(mag_yz),
    .side_in(side_d_r[RW-1][ROLL_IDX]),
    .angle(roll_a), .undef(mask_a[ROLL_IDX])
  );
  ata_cordic #(.SAMPLE_BITS(SAMPLE_BITS)) u_cordic_pitch (
    .clk(clk), .en(pipe_en),
    .num_mag({ay_d_r[RW-1], FRAC_BITS'(0)}), .den_mag(mag_xz),
    .side_in(side_d_r[RW-1][PITCH_IDX]),
    .angle(pitch_a), .undef(mask_a[PITCH_IDX])
  );
  ata_cordic #(.SAMPLE_BITS(SAMPLE_BITS)) u_cordic_tilt (
    .clk(clk), .en(pipe_en),
    .num_mag(mag_xy), .den_mag({az_d_r[RW-1], FRAC_BITS'(0)}),
    .side_in(side_d_r[RW-1][TILT_IDX]),
    .angle(tilt_a), .undef(mask_a[TILT_IDX])
  );

  // output register, parts the pipeline from the sink
  logic signed [ANG_W-1:0] roll_r, pitch_r, tilt_r;
  logic [MASK_W-1:0]       mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en && v_r[TOT-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && v_r[TOT-1]) begin
      roll_r  <= roll_a;
      pitch_r <= pitch_a;
      tilt_r  <= tilt_a;
      mask_r  <= mask_a;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.roll_angle     = roll_r;
  assign out_chan.pitch_angle    = pitch_r;
  assign out_chan.vertical_tilt  = tilt_r;
  assign out_chan.undefined_mask = mask_r;
endmodule
`default_nettype wire

@@ hw/rtl/ata_checker.sv @@
`include "accel_tilt_angles_macros.svh"
`default_nettype none
module ata_checker import ata_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [ANG_W-1:0] roll_angle,
  input wire logic signed [ANG_W-1:0] pitch_angle,
  input wire logic signed [ANG_W-1:0] vertical_tilt,
  input wire logic [MASK_W-1:0]       undefined_mask
);
  `ATA_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result item after reset")

  `ATA_ASSERT(a_ready_follows, out_ready |-> in_ready, "input held with sink ready")

  `ATA_ASSERT(a_mask_zero, out_valid |-> (!undefined_mask[ROLL_IDX] || roll_angle == 0) && (!undefined_mask[PITCH_IDX] || pitch_angle == 0) && (!undefined_mask[TILT_IDX] || vertical_tilt == 0), "flagged angle not zero")

  `ATA_ASSERT(a_range, out_valid |-> roll_angle >= -RIGHT_ANGLE && roll_angle <= RIGHT_ANGLE && pitch_angle >= -RIGHT_ANGLE && pitch_angle <= RIGHT_ANGLE && vertical_tilt >= -RIGHT_ANGLE && vertical_tilt <= RIGHT_ANGLE, "angle out of range")

  `ATA_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(roll_angle) && $stable(pitch_angle) && $stable(vertical_tilt) && $stable(undefined_mask), "stalled item changed")
endmodule

bind accel_tilt_angles ata_checker u_ata_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .roll_angle(out_chan.roll_angle),
  .pitch_angle(out_chan.pitch_angle),
  .vertical_tilt(out_chan.vertical_tilt),
  .undefined_mask(out_chan.undefined_mask)
);
`default_nettype wire
